// ===== rtl/pibw_pkg.sv =====
// Package for the polynomial inverse warp core: image geometry, fixed-point
// coefficients, function codes and the frame store bank request type.
// No dependencies.
`default_nettype none
package pibw_pkg;
  localparam int IMAGE_SIZE = 328;
  localparam int CHANNELS   = 3;
  localparam int COORD_W    = $clog2(IMAGE_SIZE);
  localparam int CHAN_W     = 2;
  localparam int SAMPLE_W   = 8;
  localparam int HALF_SIZE  = (IMAGE_SIZE + 1) / 2;
  localparam int BANK_DEPTH = HALF_SIZE * HALF_SIZE * CHANNELS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // map coefficients, 24 fraction bits
  localparam logic signed [25:0] K_A  = 26'sd13174628;
  localparam logic signed [25:0] K_B  = 26'sd3602588;
  localparam logic signed [25:0] K_D  = 26'sd29951860;
  localparam logic signed [17:0] K_C1 = 18'sd39999;
  localparam logic signed [17:0] K_C2 = 18'sd40167;

  typedef struct packed {
    logic                en;
    logic                we;
    logic [BANK_AW-1:0]  addr;
    logic [SAMPLE_W-1:0] wdata;
  } bank_req_t;
endpackage
`default_nettype wire

// ===== rtl/pibw_in_if.sv =====
// Request channel of the warp core: valid/ready plus load/query payload.
// Depends on pibw_pkg.
`default_nettype none
interface pibw_in_if import pibw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  col;
  logic [CHAN_W-1:0]   chan;
  logic [SAMPLE_W-1:0] sample_in;
  modport source (output valid, func, row, col, chan, sample_in, input ready);
  modport sink   (input valid, func, row, col, chan, sample_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/pibw_out_if.sv =====
// Result channel of the warp core: valid/ready plus output sample.
// Depends on pibw_pkg.
`default_nettype none
interface pibw_out_if import pibw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/pibw_bank.sv =====
// One frame store bank: single-port synchronous RAM, registered read.
// Depends on pibw_pkg.
`default_nettype none
module pibw_bank import pibw_pkg::*; (
  input  wire logic                clk,
  input  wire bank_req_t           req,
  output logic      [SAMPLE_W-1:0] rdata
);
  logic [SAMPLE_W-1:0] mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end
      rdata <= mem[req.addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/polynomial_inverse_warp_bilinear_core.sv =====
// Polynomial inverse warp with bilinear interpolation, top level.
// Depends on pibw_pkg, pibw_in_if, pibw_out_if, pibw_bank.
//
// Loads (func 0) write one source byte into the frame store; queries (func 1)
// return one warped byte. The core takes one request per clock while the
// output is not stalled. The frame store is split into four single-port
// banks by row and column parity, so the four bilinear neighbours are always
// in different banks and are read together in the same cycle. Loads
// write in the same pipeline stage where queries read, so every request sees
// the store exactly as left by the requests accepted before it. The whole
// pipeline advances together; it halts only while a result waits at the
// output and the sink is not ready. The store has no reset: a query that
// touches an entry never loaded returns an unspecified value.
`default_nettype none
module polynomial_inverse_warp_bilinear_core import pibw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  pibw_in_if.sink   upstream,
  pibw_out_if.source downstream
);
  typedef enum logic [1:0] {TRI_BOTTOM, TRI_LEFT, TRI_TOP, TRI_RIGHT} tri_t;

  typedef struct packed {
    logic                valid;
    logic                query;
    logic                zero;
    logic [CHAN_W-1:0]   chan;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [SAMPLE_W-1:0] smp;
  } tag_t;

  localparam logic signed [33:0] P_BASE = 34'(IMAGE_SIZE * 65536 - 32768);
  localparam logic signed [33:0] LIM    = 34'((IMAGE_SIZE - 1) * 65536);

  logic adv;
  assign adv = !downstream.valid || downstream.ready;
  assign upstream.ready = adv;

  // ---- stage 1: input register
  tag_t t1, t2, t3, t4, t5, t6;
  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
    end else if (adv) begin
      t1.valid <= upstream.valid;
    end
    if (adv) begin
      t1.query <= (upstream.func == FUNC_QUERY);
      t1.zero  <= (32'(upstream.row) >= IMAGE_SIZE) || (32'(upstream.col) >= IMAGE_SIZE)
                  || (32'(upstream.chan) >= CHANNELS);
      t1.chan  <= upstream.chan;
      t1.row   <= upstream.row;
      t1.col   <= upstream.col;
      t1.smp   <= upstream.sample_in;
    end
  end

  // ---- stage 2: centred coordinates in half units, triangle, squares
  logic        [COORD_W:0]  x_h;     // 2*col+1
  logic signed [11:0]       y_h;     // 2*(size-row)-1
  logic                     y_le_x, sum_le;
  tri_t                     tri_s1;
  logic        [COORD_W:0]  x2r;
  logic signed [11:0]       y2r;
  logic        [20:0]       xs2, ys2;
  tri_t                     tri2;

  assign x_h    = {t1.col, 1'b1};
  assign y_h    = 12'(2 * IMAGE_SIZE - 1) - $signed({2'b0, t1.row, 1'b0});
  assign y_le_x = y_h <= $signed({2'b0, x_h});
  assign sum_le = ($signed({2'b0, x_h}) + y_h) <= 12'(2 * IMAGE_SIZE);

  always_comb begin
    if (y_le_x && sum_le)  tri_s1 = TRI_BOTTOM;
    else if (sum_le)       tri_s1 = TRI_LEFT;
    else if (!y_le_x || ($signed({2'b0, x_h}) == y_h)) tri_s1 = TRI_TOP;
    else                   tri_s1 = TRI_RIGHT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2.valid <= 1'b0;
    end else if (adv) begin
      t2.valid <= t1.valid;
    end
    if (adv) begin
      {t2.query, t2.zero, t2.chan, t2.row, t2.col, t2.smp} <=
        {t1.query, t1.zero, t1.chan, t1.row, t1.col, t1.smp};
      x2r  <= x_h;
      y2r  <= y_h;
      xs2  <= 21'(x_h * x_h);
      ys2  <= 21'(24'(y_h) * 24'(y_h));
      tri2 <= tri_s1;
    end
  end

  // ---- stage 3: four coefficient products
  logic signed [25:0] c0, c1;
  logic signed [17:0] c2, c3;
  logic signed [38:0] pr0, pr1, pr2, pr3;
  logic        [COORD_W:0] x3;
  logic signed [11:0]      y3;
  tri_t                    tri3;

  always_comb begin
    case (tri2)
      TRI_BOTTOM: begin c0 = K_A;  c1 = K_B;  c2 = -K_C1; c3 = K_C2;  end
      TRI_LEFT:   begin c0 = K_B;  c1 = K_A;  c2 = K_C2;  c3 = -K_C1; end
      TRI_TOP:    begin c0 = -K_A; c1 = K_D;  c2 = K_C2;  c3 = -K_C1; end
      default:    begin c0 = K_D;  c1 = -K_A; c2 = -K_C2; c3 = K_C2;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t3.valid <= 1'b0;
    end else if (adv) begin
      t3.valid <= t2.valid;
    end
    if (adv) begin
      {t3.query, t3.zero, t3.chan, t3.row, t3.col, t3.smp} <=
        {t2.query, t2.zero, t2.chan, t2.row, t2.col, t2.smp};
      pr0  <= 39'(c0 * $signed({2'b0, x2r, 1'b0}));
      pr1  <= 39'(c1 * $signed({y2r, 1'b0}));
      pr2  <= 39'(c2 * $signed({1'b0, xs2}));
      pr3  <= 39'(c3 * $signed({1'b0, ys2}));
      x3   <= x2r;
      y3   <= y2r;
      tri3 <= tri2;
    end
  end

  // ---- stage 4: partial sums
  logic signed [39:0] s01, s23;
  logic        [COORD_W:0] x4;
  logic signed [11:0]      y4;
  tri_t                    tri4;
  always_ff @(posedge clk) begin
    if (rst) begin
      t4.valid <= 1'b0;
    end else if (adv) begin
      t4.valid <= t3.valid;
    end
    if (adv) begin
      {t4.query, t4.zero, t4.chan, t4.row, t4.col, t4.smp} <=
        {t3.query, t3.zero, t3.chan, t3.row, t3.col, t3.smp};
      s01  <= 40'(pr0) + 40'(pr1);
      s23  <= 40'(pr2) + 40'(pr3);
      x4   <= x3;
      y4   <= y3;
      tri4 <= tri3;
    end
  end

  // ---- stage 5: map result to source point (p, q), 16 fraction bits.
  // Sum is in units of 2^-26 relative to the 2^-16 grid: floor by 10 bits.
  logic signed [40:0] s_all;
  logic signed [30:0] w_map;
  logic signed [33:0] u_s, v_s, p5, q5;
  assign s_all = 41'(s01) + 41'(s23);
  assign w_map = 31'(s_all >>> 10);
  always_comb begin
    if (tri4 == TRI_BOTTOM || tri4 == TRI_TOP) begin
      u_s = $signed({9'b0, x4, 15'b0});
      v_s = 34'(w_map);
    end else begin
      u_s = 34'(w_map);
      v_s = 34'($signed({y4, 15'b0}));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      t5.valid <= 1'b0;
    end else if (adv) begin
      t5.valid <= t4.valid;
    end
    if (adv) begin
      {t5.query, t5.zero, t5.chan, t5.row, t5.col, t5.smp} <=
        {t4.query, t4.zero, t4.chan, t4.row, t4.col, t4.smp};
      p5 <= P_BASE - v_s;
      q5 <= u_s - 34'sd32768;
    end
  end

  // ---- stage 6: range check, integer / fraction split
  logic               outside;
  logic [COORD_W-1:0] ti6, tj6;
  logic [15:0]        fp6, fq6;
  assign outside = (p5 < 0) || (p5 > LIM) || (q5 < 0) || (q5 > LIM);
  always_ff @(posedge clk) begin
    if (rst) begin
      t6.valid <= 1'b0;
    end else if (adv) begin
      t6.valid <= t5.valid;
    end
    if (adv) begin
      t6.query <= t5.query;
      t6.row   <= t5.row;
      t6.col   <= t5.col;
      t6.smp   <= t5.smp;
      if (!t5.query) begin
        t6.zero <= t5.zero;
        t6.chan <= t5.zero ? '0 : t5.chan;
        ti6 <= t5.zero ? '0 : t5.row;
        tj6 <= t5.zero ? '0 : t5.col;
        fp6 <= '0;
        fq6 <= '0;
      end else if (t5.zero || outside) begin
        t6.zero <= 1'b1;
        t6.chan <= '0;
        ti6 <= '0;
        tj6 <= '0;
        fp6 <= '0;
        fq6 <= '0;
      end else begin
        t6.zero <= 1'b0;
        t6.chan <= t5.chan;
        ti6 <= p5[16 +: COORD_W];
        tj6 <= q5[16 +: COORD_W];
        fp6 <= p5[15:0];
        fq6 <= q5[15:0];
      end
    end
  end

  // ---- bank access: bank {pr,pc} holds the neighbour of that parity.
  // A neighbour with zero weight falls back to the base row or column.
  bank_req_t           breq [4];
  logic [SAMPLE_W-1:0] bdata [4];
  logic                is_load;
  assign is_load = t6.valid && !t6.query && !t6.zero;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BSEL = 2'(b);
    logic [COORD_W-1:0] r_b, c_b;
    always_comb begin
      r_b = (ti6[0] == BSEL[1] || fp6 == '0) ? ti6 : ti6 + 1'b1;
      c_b = (tj6[0] == BSEL[0] || fq6 == '0) ? tj6 : tj6 + 1'b1;
      breq[b].en    = adv;
      breq[b].we    = is_load && ({ti6[0], tj6[0]} == BSEL);
      breq[b].addr  = BANK_AW'((32'(r_b >> 1) * HALF_SIZE + 32'(c_b >> 1)) * CHANNELS
                      + 32'(t6.chan));
      breq[b].wdata = t6.smp;
    end
    pibw_bank u_bank (.clk(clk), .req(breq[b]), .rdata(bdata[b]));
  end

  // ---- stage 7: read data arrives, weights
  logic        v7, q7, z7, ti0_7, tj0_7;
  logic [15:0] fp7, fq7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= t6.valid;
    end
    if (adv) begin
      q7    <= t6.query;
      z7    <= t6.zero;
      ti0_7 <= ti6[0];
      tj0_7 <= tj6[0];
      fp7   <= fp6;
      fq7   <= fq6;
    end
  end

  logic                v8, q8, z8;
  logic [32:0]         w8 [4];
  logic [SAMPLE_W-1:0] d8 [4];
  logic                v9, q9, z9;
  logic [40:0]         m9 [4];

  for (genvar b = 0; b < 4; b++) begin : g_wgt
    localparam logic [1:0] BSEL = 2'(b);
    logic        dr, dc;
    logic [16:0] rw, cw;
    assign dr = ti0_7 ^ BSEL[1];
    assign dc = tj0_7 ^ BSEL[0];
    assign rw = dr ? {1'b0, fp7} : 17'h10000 - {1'b0, fp7};
    assign cw = dc ? {1'b0, fq7} : 17'h10000 - {1'b0, fq7};
    always_ff @(posedge clk) begin
      if (adv) begin
        w8[b] <= 33'(rw * cw);
        d8[b] <= ((dr && fp7 == '0) || (dc && fq7 == '0) || z7) ? '0 : bdata[b];
        m9[b] <= 41'(d8[b] * w8[b]);
      end
    end
  end

  // ---- stages 8, 9: products; output register: sum, floor and saturate
  logic [42:0] acc;
  assign acc = 43'(m9[0]) + 43'(m9[1]) + 43'(m9[2]) + 43'(m9[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
      downstream.valid <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
      v9 <= v8;
      downstream.valid <= v9 && q9;
    end
    if (adv) begin
      q8 <= q7;
      z8 <= z7;
      q9 <= q8;
      z9 <= z8;
      if (z9) begin
        downstream.sample_out <= '0;
      end else if (acc[42:32] > 11'd255) begin
        downstream.sample_out <= 8'hFF;
      end else begin
        downstream.sample_out <= acc[39:32];
      end
    end
  end

  // ---- checks
  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !upstream.ready |-> (downstream.valid && !downstream.ready))
    else $error("input stalled without output backpressure");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (adv && v9 && !q9) |=> !downstream.valid)
    else $error("load produced a result");

  a_single_bank_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({breq[0].we, breq[1].we, breq[2].we, breq[3].we}))
    else $error("more than one bank written");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (adv && v9 && q9 && z9) |=> (downstream.sample_out == '0))
    else $error("out-of-range query gave nonzero result");
endmodule
`default_nettype wire
